// ===== sv/rthd_pkg.sv =====
package rthd_pkg;

   // ray parameter t: unsigned, 24 integer and 16 fraction bits
   localparam int T_INT_BITS  = 24;
   localparam int T_FRAC_BITS = 16;
   localparam int T_BITS      = T_INT_BITS + T_FRAC_BITS;
   localparam int T_HALF      = T_BITS / 2;
   localparam logic [T_BITS-1:0] T_MAX = '1;

   localparam int OFFSET_W = 48;
   localparam int DIST_W   = 48;
   localparam int MINP_W   = 16;
   localparam int TOL_W    = 32;
   localparam int CSR_W    = TOL_W;
   localparam int CSR_IDX_W = 1;

   localparam logic [MINP_W-1:0] MINP_RESET = MINP_W'(66);
   localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(262144);
   localparam logic [DIST_W-1:0] DIST_ONES  = '1;

   typedef enum logic [1:0] {
      CAUSE_HIT     = 2'd0,
      CAUSE_NEAR    = 2'd1,
      CAUSE_OUTSIDE = 2'd2
   } miss_cause_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_RAY_PARAM  = 1'b0,
      CSR_AREA_TOLERANCE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               hit;
      miss_cause_type     cause;
      logic [DIST_W-1:0]  sq_dist;
   } result_type;

endpackage

// ===== sv/ray_triangle_hit_distance.sv =====
// Ray / triangle hit test with squared travel distance, fully pipelined. One beat on req_
// carries a ray (origin, direction), the plane of a triangle (normal, offset) and its three
// vertices, all fixed point; one beat on rsp_ returns hit, miss_cause and sq_distance in
// the order the requests came in. A new request is taken every cycle while the output
// buffer has room. From the req_ beat to rsp_valid a result passes 3 stages for the
// dot products and sign handling, 40 stages of a restoring divider (one quotient bit per
// stage, this sets the depth), 5 stages for hit point, areas and distance, and the 2-entry
// output buffer. The divider's compare/subtract on the denominator width is the longest
// path. csr_ writes take effect at once and must only happen while no request is in flight.
module ray_triangle_hit_distance
   import rthd_pkg::*;
#(
   parameter int COORD_BITS = 20,
   parameter int FRAC_BITS  = 8
)(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [3*COORD_BITS-1:0]     req_ray_origin,
   input  logic [3*COORD_BITS-1:0]     req_ray_direction,
   input  logic [3*COORD_BITS-1:0]     req_plane_normal,
   input  logic signed [OFFSET_W-1:0]  req_plane_offset,
   input  logic [3*COORD_BITS-1:0]     req_vertex_p,
   input  logic [3*COORD_BITS-1:0]     req_vertex_q,
   input  logic [3*COORD_BITS-1:0]     req_vertex_r,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic [1:0]                  rsp_miss_cause,
   output logic [DIST_W-1:0]           rsp_sq_distance,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_write_data
);

   localparam int CB      = COORD_BITS;
   localparam int TWO_F   = 2 * FRAC_BITS;
   // align n.o, n.v and d to max(16, 2F) fraction bits
   localparam int SHIFT_D = (TWO_F > 16) ? TWO_F - 16 : 0;
   localparam int SHIFT_P = (TWO_F < 16) ? 16 - TWO_F : 0;
   localparam int PW      = 2 * CB;
   localparam int DOTW    = 2 * CB + 2;
   localparam int DW      = DOTW + SHIFT_P;
   localparam int NW      = ((OFFSET_W + SHIFT_D > DW) ? OFFSET_W + SHIFT_D : DW) + 1;
   localparam int SATW    = NW + DW + T_INT_BITS;
   localparam int MW      = 2 * CB;
   localparam int MH      = MW / 2;
   localparam int MHI     = MW - MH;
   localparam int DIV_N   = T_BITS;
   localparam int DL      = DIV_N - 1;
   localparam int TPW     = T_HALF + CB + 1;
   localparam int SW      = T_BITS + CB + 2;
   localparam int SCW     = CB + 2;
   localparam int PAW     = 2 * CB + 3;
   localparam int AW      = 2 * CB + 6;
   localparam int DIFFW   = AW + 2;
   localparam int CMPW    = DIFFW + TOL_W + 16;
   localparam int T2W     = 2 * T_BITS;
   localparam int NCHUNK  = T2W / T_HALF;
   localparam int PRODW   = T2W + MW;
   localparam int DS      = T_INT_BITS + TWO_F;
   localparam logic signed [SW-1:0] S_BOUND = SW'(1) << CB;

   // projected geometry that rides along the pipe
   typedef struct packed {
      logic [1:0][CB-1:0] org;
      logic [1:0][CB-1:0] vel;
      logic [1:0][CB-1:0] vp;
      logic [1:0][CB-1:0] vq;
      logic [1:0][CB-1:0] vr;
      logic [MW-1:0]      msq;
   } geo_type;

   // ---------------- configuration ----------------
   logic [MINP_W-1:0] min_ray_param_ff;
   logic [TOL_W-1:0]  area_tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ray_param_ff  <= MINP_RESET;
         area_tolerance_ff <= TOL_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_RAY_PARAM:  min_ray_param_ff  <= csr_write_data[MINP_W-1:0];
            CSR_AREA_TOLERANCE: area_tolerance_ff <= csr_write_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   // Whole pipe moves together; it only halts when the output buffer is full.
   logic [1:0] cnt_ff, cnt_in;
   logic       advance;
   logic       push, pop;

   assign advance   = (cnt_ff != 2'd2);
   assign req_ready = advance;

   // ---------------- stage 1: unpack, products, projection ----------------
   logic signed [CB-1:0] o_c [3];
   logic signed [CB-1:0] v_c [3];
   logic signed [CB-1:0] n_c [3];
   logic signed [CB-1:0] p_c [3];
   logic signed [CB-1:0] q_c [3];
   logic signed [CB-1:0] r_c [3];
   logic [1:0]           ix, iy;

   logic                 s1_vld_ff;
   logic signed [PW-1:0] s1_no_in [3], s1_no_ff [3];
   logic signed [PW-1:0] s1_nv_in [3], s1_nv_ff [3];
   logic signed [PW-1:0] s1_vv_in [3], s1_vv_ff [3];
   logic signed [OFFSET_W-1:0] s1_d_ff;
   geo_type              s1_geo_in, s1_geo_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         o_c[k] = $signed(req_ray_origin[k*CB +: CB]);
         v_c[k] = $signed(req_ray_direction[k*CB +: CB]);
         n_c[k] = $signed(req_plane_normal[k*CB +: CB]);
         p_c[k] = $signed(req_vertex_p[k*CB +: CB]);
         q_c[k] = $signed(req_vertex_q[k*CB +: CB]);
         r_c[k] = $signed(req_vertex_r[k*CB +: CB]);
         s1_no_in[k] = PW'(n_c[k]) * PW'(o_c[k]);
         s1_nv_in[k] = PW'(n_c[k]) * PW'(v_c[k]);
         s1_vv_in[k] = PW'(v_c[k]) * PW'(v_c[k]);
      end
      // drop the first nonzero normal axis; zero normal drops z
      priority if (n_c[0] != '0) begin
         ix = 2'd1; iy = 2'd2;
      end else if (n_c[1] != '0) begin
         ix = 2'd0; iy = 2'd2;
      end else begin
         ix = 2'd0; iy = 2'd1;
      end
      s1_geo_in.org[0] = o_c[ix]; s1_geo_in.org[1] = o_c[iy];
      s1_geo_in.vel[0] = v_c[ix]; s1_geo_in.vel[1] = v_c[iy];
      s1_geo_in.vp[0]  = p_c[ix]; s1_geo_in.vp[1]  = p_c[iy];
      s1_geo_in.vq[0]  = q_c[ix]; s1_geo_in.vq[1]  = q_c[iy];
      s1_geo_in.vr[0]  = r_c[ix]; s1_geo_in.vr[1]  = r_c[iy];
      s1_geo_in.msq    = '0;
   end

   // ---------------- stage 2: dot sums, numerator, denominator ----------------
   logic                   s2_vld_ff;
   logic signed [DOTW-1:0] dot_c, den_raw_c;
   logic signed [NW-1:0]   d_ext_c, dot_ext_c;
   logic signed [NW-1:0]   s2_num_in, s2_num_ff;
   logic signed [DW-1:0]   s2_den_in, s2_den_ff;
   geo_type                s2_geo_in, s2_geo_ff;

   always_comb begin
      dot_c     = DOTW'(s1_no_ff[0]) + DOTW'(s1_no_ff[1]) + DOTW'(s1_no_ff[2]);
      den_raw_c = DOTW'(s1_nv_ff[0]) + DOTW'(s1_nv_ff[1]) + DOTW'(s1_nv_ff[2]);
      d_ext_c   = NW'(s1_d_ff);
      dot_ext_c = NW'(dot_c);
      s2_num_in = (d_ext_c <<< SHIFT_D) - (dot_ext_c <<< SHIFT_P);
      s2_den_in = DW'(den_raw_c) <<< SHIFT_P;
      s2_geo_in = s1_geo_ff;
      s2_geo_in.msq = MW'(s1_vv_ff[0]) + MW'(s1_vv_ff[1]) + MW'(s1_vv_ff[2]);
   end

   // ---------------- stage 3: sign fix, early miss, saturation ----------------
   logic                 s3_vld_ff;
   logic signed [NW-1:0] num_f_c;
   logic signed [DW-1:0] den_f_c;
   logic [SATW-1:0]      sat_lhs_c, sat_rhs_c;
   logic [NW-1:0]        s3_numa_in, s3_numa_ff;
   logic [DW-1:0]        s3_dena_in, s3_dena_ff;
   logic                 s3_miss_in, s3_miss_ff;
   logic                 s3_sat_in, s3_sat_ff;
   geo_type              s3_geo_ff;

   always_comb begin
      num_f_c    = s2_den_ff[DW-1] ? -s2_num_ff : s2_num_ff;
      den_f_c    = s2_den_ff[DW-1] ? -s2_den_ff : s2_den_ff;
      // parallel ray or negative parameter
      s3_miss_in = (s2_den_ff == '0) || num_f_c[NW-1];
      s3_numa_in = num_f_c;
      s3_dena_in = den_f_c;
      sat_lhs_c  = SATW'(s3_numa_in);
      sat_rhs_c  = SATW'(s3_dena_in) << T_INT_BITS;
      s3_sat_in  = (sat_lhs_c >= sat_rhs_c);
   end

   // ---------------- stages 4..43: restoring divider ----------------
   // t = floor(num * 2^16 / den); the remainder starts at num >> 24, which is below den
   // whenever t does not saturate, then the low num bits and 16 zeros are shifted in.
   logic                div_vld_ff  [DIV_N];
   logic [DW-1:0]       div_rem_ff  [DIV_N];
   logic [T_BITS-1:0]   div_dq_ff   [DIV_N];
   logic [DW-1:0]       div_dena_ff [DIV_N];
   logic                div_miss_ff [DIV_N];
   logic                div_sat_ff  [DIV_N];
   geo_type             div_geo_ff  [DIV_N];

   logic [DW-1:0]       div_src_rem  [DIV_N];
   logic [T_BITS-1:0]   div_src_dq   [DIV_N];
   logic [DW-1:0]       div_src_dena [DIV_N];
   logic                div_src_miss [DIV_N];
   logic                div_src_sat  [DIV_N];
   geo_type             div_src_geo  [DIV_N];
   logic                div_src_vld  [DIV_N];
   logic [DW:0]         div_r2       [DIV_N];
   logic                div_ge       [DIV_N];
   logic [DW-1:0]       div_rem_in   [DIV_N];
   logic [T_BITS-1:0]   div_dq_in    [DIV_N];

   always_comb begin
      div_src_rem[0]  = DW'(s3_numa_ff >> T_INT_BITS);
      div_src_dq[0]   = {s3_numa_ff[T_INT_BITS-1:0], {T_FRAC_BITS{1'b0}}};
      div_src_dena[0] = s3_dena_ff;
      div_src_miss[0] = s3_miss_ff;
      div_src_sat[0]  = s3_sat_ff;
      div_src_geo[0]  = s3_geo_ff;
      div_src_vld[0]  = s3_vld_ff;
      for (int i = 1; i < DIV_N; i++) begin
         div_src_rem[i]  = div_rem_ff[i-1];
         div_src_dq[i]   = div_dq_ff[i-1];
         div_src_dena[i] = div_dena_ff[i-1];
         div_src_miss[i] = div_miss_ff[i-1];
         div_src_sat[i]  = div_sat_ff[i-1];
         div_src_geo[i]  = div_geo_ff[i-1];
         div_src_vld[i]  = div_vld_ff[i-1];
      end
      for (int i = 0; i < DIV_N; i++) begin
         div_r2[i]     = {div_src_rem[i], div_src_dq[i][T_BITS-1]};
         div_ge[i]     = (div_r2[i] >= {1'b0, div_src_dena[i]});
         div_rem_in[i] = div_ge[i] ? DW'(div_r2[i] - {1'b0, div_src_dena[i]})
                                   : DW'(div_r2[i]);
         div_dq_in[i]  = {div_src_dq[i][T_BITS-2:0], div_ge[i]};
      end
   end

   // ---------------- stage 44: t, near test, partial products ----------------
   logic                  s4_vld_ff;
   logic [T_BITS-1:0]     t_c;
   logic [T_HALF-1:0]     th_c, tl_c;
   logic                  s4_miss_in, s4_miss_ff;
   logic                  s4_sat_ff;
   logic signed [TPW-1:0] s4_ph_in [2], s4_ph_ff [2];
   logic signed [TPW-1:0] s4_pl_in [2], s4_pl_ff [2];
   logic [T_BITS-1:0]     s4_hh_in, s4_hh_ff;
   logic [T_BITS-1:0]     s4_hl_in, s4_hl_ff;
   logic [T_BITS-1:0]     s4_ll_in, s4_ll_ff;
   geo_type               s4_geo_ff;

   always_comb begin
      t_c        = div_sat_ff[DL] ? T_MAX : div_dq_ff[DL];
      th_c       = t_c[T_BITS-1:T_HALF];
      tl_c       = t_c[T_HALF-1:0];
      s4_miss_in = div_miss_ff[DL] || (t_c < T_BITS'(min_ray_param_ff));
      for (int k = 0; k < 2; k++) begin
         s4_ph_in[k] = TPW'($signed({1'b0, th_c}))
                     * TPW'($signed(div_geo_ff[DL].vel[k]));
         s4_pl_in[k] = TPW'($signed({1'b0, tl_c}))
                     * TPW'($signed(div_geo_ff[DL].vel[k]));
      end
      s4_hh_in = T_BITS'(th_c) * T_BITS'(th_c);
      s4_hl_in = T_BITS'(th_c) * T_BITS'(tl_c);
      s4_ll_in = T_BITS'(tl_c) * T_BITS'(tl_c);
   end

   // ---------------- stage 45: hit point S, t squared ----------------
   logic                  s5_vld_ff;
   logic signed [SW-1:0]  s_full_c [2];
   logic signed [SW-1:0]  s_fl_c   [2];
   logic signed [SCW-1:0] s5_s_in [2], s5_s_ff [2];
   logic [T2W-1:0]        s5_t2_in, s5_t2_ff;
   logic                  s5_miss_ff, s5_sat_ff;
   geo_type               s5_geo_ff;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         s_full_c[k] = (SW'($signed(s4_geo_ff.org[k])) <<< T_FRAC_BITS)
                     + (SW'(s4_ph_ff[k]) <<< T_HALF) + SW'(s4_pl_ff[k]);
         s_fl_c[k]   = s_full_c[k] >>> T_FRAC_BITS;   // floor
         priority if (s_fl_c[k] > S_BOUND)
            s5_s_in[k] = SCW'(S_BOUND);
         else if (s_fl_c[k] < -S_BOUND)
            s5_s_in[k] = SCW'(-S_BOUND);
         else
            s5_s_in[k] = SCW'(s_fl_c[k]);
      end
      s5_t2_in = (T2W'(s4_hh_ff) << (2 * T_HALF)) + (T2W'(s4_hl_ff) << (T_HALF + 1))
               + T2W'(s4_ll_ff);
   end

   // ---------------- stage 46: area and distance products ----------------
   // triangles: PQR, PQS, PRS, QRS; r is the third corner
   logic                  s6_vld_ff;
   logic signed [CB-1:0]  ta_px [4], ta_py [4], ta_qx [4], ta_qy [4];
   logic signed [SCW-1:0] ta_rx [4], ta_ry [4];
   logic signed [CB:0]    ta_dy [4], ta_dx [4];
   logic signed [PAW-1:0] s6_tp_in [4][4], s6_tp_ff [4][4];
   logic [T_HALF+MH-1:0]  s6_dl_in [NCHUNK], s6_dl_ff [NCHUNK];
   logic [T_HALF+MHI-1:0] s6_dh_in [NCHUNK], s6_dh_ff [NCHUNK];
   logic                  s6_miss_ff, s6_sat_ff;

   always_comb begin
      ta_px[0] = $signed(s5_geo_ff.vp[0]); ta_py[0] = $signed(s5_geo_ff.vp[1]);
      ta_qx[0] = $signed(s5_geo_ff.vq[0]); ta_qy[0] = $signed(s5_geo_ff.vq[1]);
      ta_rx[0] = SCW'($signed(s5_geo_ff.vr[0]));
      ta_ry[0] = SCW'($signed(s5_geo_ff.vr[1]));
      ta_px[1] = $signed(s5_geo_ff.vp[0]); ta_py[1] = $signed(s5_geo_ff.vp[1]);
      ta_qx[1] = $signed(s5_geo_ff.vq[0]); ta_qy[1] = $signed(s5_geo_ff.vq[1]);
      ta_px[2] = $signed(s5_geo_ff.vp[0]); ta_py[2] = $signed(s5_geo_ff.vp[1]);
      ta_qx[2] = $signed(s5_geo_ff.vr[0]); ta_qy[2] = $signed(s5_geo_ff.vr[1]);
      ta_px[3] = $signed(s5_geo_ff.vq[0]); ta_py[3] = $signed(s5_geo_ff.vq[1]);
      ta_qx[3] = $signed(s5_geo_ff.vr[0]); ta_qy[3] = $signed(s5_geo_ff.vr[1]);
      for (int i = 1; i < 4; i++) begin
         ta_rx[i] = s5_s_ff[0];
         ta_ry[i] = s5_s_ff[1];
      end
      for (int i = 0; i < 4; i++) begin
         ta_dy[i] = (CB+1)'(ta_py[i]) - (CB+1)'(ta_qy[i]);
         ta_dx[i] = (CB+1)'(ta_qx[i]) - (CB+1)'(ta_px[i]);
         s6_tp_in[i][0] = PAW'(ta_dy[i]) * PAW'(ta_rx[i]);
         s6_tp_in[i][1] = PAW'(ta_dx[i]) * PAW'(ta_ry[i]);
         s6_tp_in[i][2] = PAW'(ta_px[i]) * PAW'(ta_qy[i]);
         s6_tp_in[i][3] = PAW'(ta_py[i]) * PAW'(ta_qx[i]);
      end
      for (int j = 0; j < NCHUNK; j++) begin
         s6_dl_in[j] = (T_HALF+MH)'(s5_t2_ff[j*T_HALF +: T_HALF])
                     * (T_HALF+MH)'(s5_geo_ff.msq[MH-1:0]);
         s6_dh_in[j] = (T_HALF+MHI)'(s5_t2_ff[j*T_HALF +: T_HALF])
                     * (T_HALF+MHI)'(s5_geo_ff.msq[MW-1:MH]);
      end
   end

   // ---------------- stage 47: areas, distance column sums ----------------
   logic                 s7_vld_ff;
   logic signed [AW-1:0] area_s_c [4];
   logic [AW-1:0]        s7_area_in [4], s7_area_ff [4];
   logic [PRODW-1:0]     s7_sl_in, s7_sl_ff;
   logic [PRODW-1:0]     s7_sh_in, s7_sh_ff;
   logic                 s7_miss_ff, s7_sat_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         area_s_c[i]   = AW'(s6_tp_ff[i][0]) + AW'(s6_tp_ff[i][1])
                       + AW'(s6_tp_ff[i][2]) - AW'(s6_tp_ff[i][3]);
         s7_area_in[i] = area_s_c[i][AW-1] ? AW'(-area_s_c[i]) : AW'(area_s_c[i]);
      end
      s7_sl_in = '0;
      s7_sh_in = '0;
      for (int j = 0; j < NCHUNK; j++) begin
         s7_sl_in = s7_sl_in + (PRODW'(s6_dl_ff[j]) << (j * T_HALF));
         s7_sh_in = s7_sh_in + (PRODW'(s6_dh_ff[j]) << (j * T_HALF));
      end
   end

   // ---------------- stage 48: area test, full distance product ----------------
   logic                    s8_vld_ff;
   logic signed [DIFFW-1:0] diff_c;
   logic [DIFFW-1:0]        ad_c;
   logic [CMPW-1:0]         cmp_lhs_c, cmp_rhs_c;
   logic                    s8_inside_in, s8_inside_ff;
   logic [PRODW-1:0]        s8_prod_in, s8_prod_ff;
   logic                    s8_miss_ff, s8_sat_ff;

   always_comb begin
      diff_c = $signed({2'b00, s7_area_ff[0]}) - $signed({2'b00, s7_area_ff[1]})
             - $signed({2'b00, s7_area_ff[2]}) - $signed({2'b00, s7_area_ff[3]});
      ad_c   = diff_c[DIFFW-1] ? DIFFW'(-diff_c) : DIFFW'(diff_c);
      cmp_lhs_c    = CMPW'(ad_c) << SHIFT_P;
      cmp_rhs_c    = CMPW'(area_tolerance_ff) << SHIFT_D;
      s8_inside_in = (cmp_lhs_c < cmp_rhs_c);
      s8_prod_in   = s7_sl_ff + (s7_sh_ff << MH);
   end

   // ---------------- result ----------------
   result_type res_c;

   always_comb begin
      res_c.hit     = 1'b0;
      res_c.sq_dist = DIST_ONES;
      priority if (s8_miss_ff) begin
         res_c.cause = CAUSE_NEAR;
      end else if (!s8_inside_ff) begin
         res_c.cause = CAUSE_OUTSIDE;
      end else begin
         res_c.hit   = 1'b1;
         res_c.cause = CAUSE_HIT;
         if (!s8_sat_ff && (s8_prod_ff[PRODW-1:DS+DIST_W] == '0))
            res_c.sq_dist = s8_prod_ff[DS +: DIST_W];
      end
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         for (int i = 0; i < DIV_N; i++)
            div_vld_ff[i] <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         for (int i = 0; i < DIV_N; i++)
            div_vld_ff[i] <= div_src_vld[i];
         s4_vld_ff <= div_vld_ff[DL];
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_no_ff  <= s1_no_in;
         s1_nv_ff  <= s1_nv_in;
         s1_vv_ff  <= s1_vv_in;
         s1_d_ff   <= req_plane_offset;
         s1_geo_ff <= s1_geo_in;

         s2_num_ff <= s2_num_in;
         s2_den_ff <= s2_den_in;
         s2_geo_ff <= s2_geo_in;

         s3_numa_ff <= s3_numa_in;
         s3_dena_ff <= s3_dena_in;
         s3_miss_ff <= s3_miss_in;
         s3_sat_ff  <= s3_sat_in;
         s3_geo_ff  <= s2_geo_ff;

         for (int i = 0; i < DIV_N; i++) begin
            div_rem_ff[i]  <= div_rem_in[i];
            div_dq_ff[i]   <= div_dq_in[i];
            div_dena_ff[i] <= div_src_dena[i];
            div_miss_ff[i] <= div_src_miss[i];
            div_sat_ff[i]  <= div_src_sat[i];
            div_geo_ff[i]  <= div_src_geo[i];
         end

         s4_miss_ff <= s4_miss_in;
         s4_sat_ff  <= div_sat_ff[DL];
         s4_ph_ff   <= s4_ph_in;
         s4_pl_ff   <= s4_pl_in;
         s4_hh_ff   <= s4_hh_in;
         s4_hl_ff   <= s4_hl_in;
         s4_ll_ff   <= s4_ll_in;
         s4_geo_ff  <= div_geo_ff[DL];

         s5_s_ff    <= s5_s_in;
         s5_t2_ff   <= s5_t2_in;
         s5_miss_ff <= s4_miss_ff;
         s5_sat_ff  <= s4_sat_ff;
         s5_geo_ff  <= s4_geo_ff;

         s6_tp_ff   <= s6_tp_in;
         s6_dl_ff   <= s6_dl_in;
         s6_dh_ff   <= s6_dh_in;
         s6_miss_ff <= s5_miss_ff;
         s6_sat_ff  <= s5_sat_ff;

         s7_area_ff <= s7_area_in;
         s7_sl_ff   <= s7_sl_in;
         s7_sh_ff   <= s7_sh_in;
         s7_miss_ff <= s6_miss_ff;
         s7_sat_ff  <= s6_sat_ff;

         s8_inside_ff <= s8_inside_in;
         s8_prod_ff   <= s8_prod_in;
         s8_miss_ff   <= s7_miss_ff;
         s8_sat_ff    <= s7_sat_ff;
      end
   end

   // ---------------- output buffer, 2 beats ----------------
   // slot0 is the head. req_ready comes from the fill count only, so the
   // consumer's ready never reaches the input side combinationally.
   result_type slot0_ff, slot1_ff;

   assign push   = advance && s8_vld_ff;
   assign pop    = rsp_valid && rsp_ready;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset)
         cnt_ff <= 2'd0;
      else
         cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      priority if (pop && (cnt_ff == 2'd2))
         slot0_ff <= slot1_ff;
      else if (push && ((cnt_ff == 2'd0) || pop))
         slot0_ff <= res_c;
      if (push && (cnt_ff == 2'd1) && !pop)
         slot1_ff <= res_c;
   end

   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_hit         = slot0_ff.hit;
   assign rsp_miss_cause  = slot0_ff.cause;
   assign rsp_sq_distance = slot0_ff.sq_dist;

endmodule
